/* src/rs485rb_pkg.sv */
// shared constants and command codes for the rs485 uart ring buffers
`default_nettype none
package rs485rb_pkg;

	// ring sizes, one slot of each ring always stays empty
	localparam int RX_DEPTH = 64;
	localparam int TX_DEPTH = 64;
	localparam int RX_IDX_W = $clog2(RX_DEPTH);
	localparam int TX_IDX_W = $clog2(TX_DEPTH);

	// field widths
	localparam int CMD_W     = 3;
	localparam int DATA_W    = 8;
	localparam int RX_BYTE_W = 7;
	localparam int TX_BYTE_W = 8;
	localparam int OUT_W     = 24;

	// command codes carried on s_tuser
	localparam logic [CMD_W-1:0] CMD_RX_BYTE    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HOST_READ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HOST_WRITE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TX_READY   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TX_DONE    = 3'd4;

endpackage
`default_nettype wire

/* src/rs485rb_ram.sv */
// simple dual port ram, one write and one registered read per cycle
`default_nettype none
module rs485rb_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* src/rs485_uart_ring_buffers.sv */
// rs485 uart receive and transmit rings with line direction control
//
// channel | signals                          | carries
// --------+----------------------------------+----------------------------------------
// in      | s_tvalid s_tready s_tuser s_tdata | one command item: cmd on tuser, data on tdata
// out     | m_tvalid m_tready m_tdata        | one result item per command item
//
// every item is decoded and applied to the ring indices and the direction
// state in the cycle it is accepted; the store access of that item happens at the
// same edge, so one item per cycle is sustained as long as no result stalls, and the result
// appears in the next cycle. the output register is the only stage: a new item is taken
// while the result is taken in the same cycle. arst_n clears indices, the
// transmit enable, the armed release, the direction and the output valid; the
// stores hold nothing meaningful until written. a stalled result holds the
// input side off.
`default_nettype none
module rs485_uart_ring_buffers (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [rs485rb_pkg::DATA_W-1:0]   s_tdata,  // [7:0] data
	input  wire logic [rs485rb_pkg::CMD_W-1:0]    s_tuser,  // [2:0] cmd
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// [0] read_valid, [7:1] read_data, [8] write_accepted, [9] tx_valid,
	// [17:10] tx_byte, [18] driver_transmit, [19] rx_overflow, [23:20] zero
	output      logic [rs485rb_pkg::OUT_W-1:0]    m_tdata
);

	localparam int RXW = rs485rb_pkg::RX_IDX_W;
	localparam int TXW = rs485rb_pkg::TX_IDX_W;

	// ring state
	logic [RXW-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [TXW-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d;
	logic           tx_en_q, tx_en_d;
	logic           armed_q, armed_d;
	logic           dir_q, dir_d;

	// wrapped successors of each index
	logic [RXW-1:0] rx_head_nx, rx_tail_nx;
	logic [TXW-1:0] tx_head_nx, tx_tail_nx;

	// decode results
	logic rx_wr, rx_rd, tx_wr, tx_rd;
	logic rd_valid_c, wr_acc_c, tx_valid_c, ovf_c;

	// output stage
	logic valid_s1;
	logic read_valid_s1, write_accepted_s1, tx_valid_s1, direction_s1, overflow_s1;
	logic [rs485rb_pkg::RX_BYTE_W-1:0] rx_rd_data;
	logic [rs485rb_pkg::TX_BYTE_W-1:0] tx_rd_data;

	logic accept;

	// input side opens when the result register is empty or being drained
	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	// indices wrap from depth-1 to 0
	assign rx_head_nx = (rx_head_q == RXW'(rs485rb_pkg::RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
	assign rx_tail_nx = (rx_tail_q == RXW'(rs485rb_pkg::RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
	assign tx_head_nx = (tx_head_q == TXW'(rs485rb_pkg::TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
	assign tx_tail_nx = (tx_tail_q == TXW'(rs485rb_pkg::TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;

	// command decode
	always_comb begin
		rx_head_d  = rx_head_q;
		rx_tail_d  = rx_tail_q;
		tx_head_d  = tx_head_q;
		tx_tail_d  = tx_tail_q;
		tx_en_d    = tx_en_q;
		armed_d    = armed_q;
		dir_d      = dir_q;
		rx_wr      = 1'b0;
		rx_rd      = 1'b0;
		tx_wr      = 1'b0;
		tx_rd      = 1'b0;
		rd_valid_c = 1'b0;
		wr_acc_c   = 1'b0;
		tx_valid_c = 1'b0;
		ovf_c      = 1'b0;
		unique case (s_tuser)
			rs485rb_pkg::CMD_RX_BYTE: begin
				// head always advances; catching the tail loses the ring content
				rx_wr     = 1'b1;
				rx_head_d = rx_head_nx;
				ovf_c     = (rx_head_nx == rx_tail_q);
			end
			rs485rb_pkg::CMD_HOST_READ: begin
				if (rx_head_q != rx_tail_q) begin
					rx_rd      = 1'b1;
					rx_tail_d  = rx_tail_nx;
					rd_valid_c = 1'b1;
				end
			end
			rs485rb_pkg::CMD_HOST_WRITE: begin
				// driver turns to transmit even when the ring is full
				dir_d = 1'b1;
				if (tx_head_nx != tx_tail_q) begin
					tx_wr     = 1'b1;
					tx_head_d = tx_head_nx;
					tx_en_d   = 1'b1;
					wr_acc_c  = 1'b1;
				end
			end
			rs485rb_pkg::CMD_TX_READY: begin
				if (tx_en_q) begin
					if (tx_head_q != tx_tail_q) begin
						tx_rd      = 1'b1;
						tx_tail_d  = tx_tail_nx;
						tx_valid_c = 1'b1;
					end else begin
						// ring drained: stop and arm the direction release
						tx_en_d = 1'b0;
						armed_d = 1'b1;
					end
				end
			end
			rs485rb_pkg::CMD_TX_DONE: begin
				if (armed_q) begin
					dir_d   = 1'b0;
					armed_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// ring indices, direction state and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q         <= '0;
			rx_tail_q         <= '0;
			tx_head_q         <= '0;
			tx_tail_q         <= '0;
			tx_en_q           <= 1'b0;
			armed_q           <= 1'b0;
			dir_q             <= 1'b0;
			valid_s1          <= 1'b0;
			read_valid_s1     <= 1'b0;
			write_accepted_s1 <= 1'b0;
			tx_valid_s1       <= 1'b0;
			direction_s1      <= 1'b0;
			overflow_s1       <= 1'b0;
		end else begin
			if (accept) begin
				rx_head_q         <= rx_head_d;
				rx_tail_q         <= rx_tail_d;
				tx_head_q         <= tx_head_d;
				tx_tail_q         <= tx_tail_d;
				tx_en_q           <= tx_en_d;
				armed_q           <= armed_d;
				dir_q             <= dir_d;
				read_valid_s1     <= rd_valid_c;
				write_accepted_s1 <= wr_acc_c;
				tx_valid_s1       <= tx_valid_c;
				direction_s1      <= dir_d;
				overflow_s1       <= ovf_c;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (m_tready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// receive store: line bytes masked to seven bits
	rs485rb_ram #(
		.DEPTH(rs485rb_pkg::RX_DEPTH),
		.WIDTH(rs485rb_pkg::RX_BYTE_W)
	) u_rx_ram (
		.clk    (clk),
		.wr_en  (accept && rx_wr),
		.wr_addr(rx_head_nx),
		.wr_data(s_tdata[rs485rb_pkg::RX_BYTE_W-1:0]),
		.rd_en  (accept && rx_rd),
		.rd_addr(rx_tail_nx),
		.rd_data(rx_rd_data)
	);

	// transmit store: host bytes with the top bit forced high
	rs485rb_ram #(
		.DEPTH(rs485rb_pkg::TX_DEPTH),
		.WIDTH(rs485rb_pkg::TX_BYTE_W)
	) u_tx_ram (
		.clk    (clk),
		.wr_en  (accept && tx_wr),
		.wr_addr(tx_head_nx),
		.wr_data({1'b1, s_tdata[rs485rb_pkg::DATA_W-2:0]}),
		.rd_en  (accept && tx_rd),
		.rd_addr(tx_tail_nx),
		.rd_data(tx_rd_data)
	);

	// result packing; popped bytes are zero unless their flag is set
	assign m_tvalid = valid_s1;
	assign m_tdata  = {
		4'b0000,
		overflow_s1,
		direction_s1,
		tx_valid_s1 ? tx_rd_data : {rs485rb_pkg::TX_BYTE_W{1'b0}},
		tx_valid_s1,
		write_accepted_s1,
		read_valid_s1 ? rx_rd_data : {rs485rb_pkg::RX_BYTE_W{1'b0}},
		read_valid_s1
	};

endmodule
`default_nettype wire
